// ===== rtl/wmr_pkg.sv =====
// Shared types and constants for the wired mailbox router.
// Used by wmr_ctrl, wmr_dpath and wired_mailbox_router; no dependencies.
`timescale 1ns / 1ps

package wmr_pkg;

   localparam int OP_W     = 3;
   localparam int NODE_FW  = 3;
   localparam int PORT_FW  = 2;
   localparam int VALUE_W  = 31;
   localparam int WIDX_FW  = 5;
   localparam int TTL_W    = 19;
   localparam int TYPE_W   = 3;
   localparam int STATUS_W = 3;
   localparam int EVENT_W  = 6;
   localparam int FILL_W   = 4;
   localparam int CLOCK_W  = 48;

   localparam logic [TTL_W-1:0]   TTL_MAX    = 19'd300000;
   localparam logic [VALUE_W-1:0] WORD16_MAX = 31'd65535;

   // signal type codes
   localparam logic [TYPE_W-1:0] SIG_NONE   = 3'd0;
   localparam logic [TYPE_W-1:0] SIG_ZERO   = 3'd1;
   localparam logic [TYPE_W-1:0] SIG_BOOL   = 3'd2;
   localparam logic [TYPE_W-1:0] SIG_WORD   = 3'd3;
   localparam logic [TYPE_W-1:0] SIG_ANY    = 3'd4;
   localparam logic [TYPE_W-1:0] SIG_WORD_B = 3'd5;
   localparam logic [TYPE_W-1:0] SIG_BOOL_B = 3'd6;

   typedef enum logic [OP_W-1:0] {
      OP_TICK     = 3'd0,
      OP_EMIT     = 3'd1,
      OP_RECEIVE  = 3'd2,
      OP_WIRE     = 3'd3,
      OP_IN_PORT  = 3'd4,
      OP_OUT_PORT = 3'd5
   } wmr_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 3'd0,
      ST_RANGE  = 3'd1,
      ST_FULL   = 3'd2,
      ST_UNDECL = 3'd3,
      ST_EMPTY  = 3'd4
   } wmr_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_PF_WIRE,
      S_PF_FIND,
      S_PF_CMP,
      S_PF_COUNT,
      S_DL_START,
      S_DL_WIRE,
      S_DL_FIND,
      S_DL_CMP,
      S_DL_WRITE,
      S_RX_CHK,
      S_RX_EVAL,
      S_RESP
   } wmr_state_type;

   typedef struct packed {
      logic [CLOCK_W-1:0] expiry;
      logic [PORT_FW-1:0] port;
      logic [VALUE_W-1:0] value;
   } wmr_entry_type;

   typedef struct packed {
      logic                capture;
      logic                tick;
      logic                tbl_write;
      logic                emit_init;
      logic                wire_load;
      logic                find_read;
      logic                find_cmp;
      logic                pf_count;
      logic                idx_next;
      logic                dl_init;
      logic                deliver;
      logic                rx_read;
      logic                rx_drop;
      logic                rx_pop;
      logic                rsp_load;
      logic [STATUS_W-1:0] status;
   } wmr_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            node_ok;
      logic            emit_undecl;
      logic            value_bad;
      logic            idx_end;
      logic            wire_use;
      logic            find_done;
      logic            pf_full;
      logic            rx_empty;
      logic            rx_expired;
      logic            out_free;
   } wmr_stat_type;

   function automatic logic value_fits(input logic [TYPE_W-1:0] t,
                                       input logic [VALUE_W-1:0] v);
      logic ok;
      ok = 1'b1;
      if (t == SIG_BOOL || t == SIG_BOOL_B) begin
         ok = (v <= 31'd1);
      end else if (t == SIG_ZERO) begin
         ok = (v == '0);
      end else if (t == SIG_WORD || t == SIG_WORD_B) begin
         ok = (v <= WORD16_MAX);
      end
      return ok;
   endfunction

endpackage

// ===== rtl/wmr_ctrl.sv =====
// Sequencer for the wired mailbox router: walks tick, emit, receive and table ops.
// Depends on wmr_pkg; drives wmr_dpath through the command struct.
`timescale 1ns / 1ps

module wmr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  wmr_pkg::wmr_stat_type stat,
   output wmr_pkg::wmr_cmd_type  cmd
);

   wmr_pkg::wmr_state_type            state_ff, state_in;
   logic [wmr_pkg::STATUS_W-1:0]      code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wmr_pkg::S_IDLE;
         code_ff  <= wmr_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      code_in    = code_ff;
      cmd        = '0;
      cmd.status = code_ff;
      req_ready  = 1'b0;
      case (state_ff)
         wmr_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = wmr_pkg::S_DISPATCH;
            end
         end
         wmr_pkg::S_DISPATCH: begin
            code_in  = wmr_pkg::ST_OK;
            state_in = wmr_pkg::S_RESP;
            case (stat.op)
               wmr_pkg::OP_TICK: begin
                  cmd.tick = 1'b1;
               end
               wmr_pkg::OP_EMIT: begin
                  if (stat.emit_undecl) begin
                     code_in = wmr_pkg::ST_UNDECL;
                  end else if (stat.value_bad) begin
                     code_in = wmr_pkg::ST_RANGE;
                  end else begin
                     cmd.emit_init = 1'b1;
                     state_in      = wmr_pkg::S_PF_WIRE;
                  end
               end
               wmr_pkg::OP_RECEIVE: begin
                  if (!stat.node_ok) begin
                     code_in = wmr_pkg::ST_EMPTY;
                  end else begin
                     state_in = wmr_pkg::S_RX_CHK;
                  end
               end
               default: begin
                  cmd.tbl_write = 1'b1;
               end
            endcase
         end
         // preflight: count room needed per recipient before touching anything
         wmr_pkg::S_PF_WIRE: begin
            if (stat.idx_end) begin
               state_in = wmr_pkg::S_DL_START;
            end else if (stat.wire_use) begin
               cmd.wire_load = 1'b1;
               state_in      = wmr_pkg::S_PF_FIND;
            end else begin
               cmd.idx_next = 1'b1;
            end
         end
         wmr_pkg::S_PF_FIND: begin
            if (stat.find_done) begin
               state_in = wmr_pkg::S_PF_COUNT;
            end else begin
               cmd.find_read = 1'b1;
               state_in      = wmr_pkg::S_PF_CMP;
            end
         end
         wmr_pkg::S_PF_CMP: begin
            cmd.find_cmp = 1'b1;
            state_in     = wmr_pkg::S_PF_FIND;
         end
         wmr_pkg::S_PF_COUNT: begin
            if (stat.pf_full) begin
               code_in  = wmr_pkg::ST_FULL;
               state_in = wmr_pkg::S_RESP;
            end else begin
               cmd.pf_count = 1'b1;
               state_in     = wmr_pkg::S_PF_WIRE;
            end
         end
         wmr_pkg::S_DL_START: begin
            cmd.dl_init = 1'b1;
            state_in    = wmr_pkg::S_DL_WIRE;
         end
         wmr_pkg::S_DL_WIRE: begin
            if (stat.idx_end) begin
               code_in  = wmr_pkg::ST_OK;
               state_in = wmr_pkg::S_RESP;
            end else if (stat.wire_use) begin
               cmd.wire_load = 1'b1;
               state_in      = wmr_pkg::S_DL_FIND;
            end else begin
               cmd.idx_next = 1'b1;
            end
         end
         wmr_pkg::S_DL_FIND: begin
            if (stat.find_done) begin
               state_in = wmr_pkg::S_DL_WRITE;
            end else begin
               cmd.find_read = 1'b1;
               state_in      = wmr_pkg::S_DL_CMP;
            end
         end
         wmr_pkg::S_DL_CMP: begin
            cmd.find_cmp = 1'b1;
            state_in     = wmr_pkg::S_DL_FIND;
         end
         wmr_pkg::S_DL_WRITE: begin
            cmd.deliver = 1'b1;
            state_in    = wmr_pkg::S_DL_WIRE;
         end
         wmr_pkg::S_RX_CHK: begin
            if (stat.rx_empty) begin
               code_in  = wmr_pkg::ST_EMPTY;
               state_in = wmr_pkg::S_RESP;
            end else begin
               cmd.rx_read = 1'b1;
               state_in    = wmr_pkg::S_RX_EVAL;
            end
         end
         wmr_pkg::S_RX_EVAL: begin
            if (stat.rx_expired) begin
               cmd.rx_drop = 1'b1;
               state_in    = wmr_pkg::S_RX_CHK;
            end else begin
               cmd.rx_pop = 1'b1;
               code_in    = wmr_pkg::ST_OK;
               state_in   = wmr_pkg::S_RESP;
            end
         end
         wmr_pkg::S_RESP: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = wmr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wmr_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/wmr_dpath.sv =====
// Datapath of the wired mailbox router: tables, inbox memory, clock, result word.
// Depends on wmr_pkg; sequenced by wmr_ctrl through command and status structs.
`timescale 1ns / 1ps

module wmr_dpath #(
   parameter int NUM_NODES      = 8,
   parameter int PORTS_PER_NODE = 4,
   parameter int INBOX_DEPTH    = 8,
   parameter int NUM_WIRES      = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wmr_pkg::wmr_cmd_type                cmd,
   output wmr_pkg::wmr_stat_type               stat,
   input  logic [wmr_pkg::OP_W-1:0]            req_op,
   input  logic [wmr_pkg::NODE_FW-1:0]         req_node,
   input  logic [wmr_pkg::PORT_FW-1:0]         req_port,
   input  logic [wmr_pkg::VALUE_W-1:0]         req_value,
   input  logic [wmr_pkg::WIDX_FW-1:0]         req_wire_index,
   input  logic [wmr_pkg::NODE_FW-1:0]         req_target_node,
   input  logic [wmr_pkg::PORT_FW-1:0]         req_target_port,
   input  logic                                req_flag,
   input  logic [wmr_pkg::TTL_W-1:0]           req_expiry_ms,
   input  logic [wmr_pkg::TYPE_W-1:0]          req_signal_type,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wmr_pkg::STATUS_W-1:0]        rsp_status,
   output logic [wmr_pkg::PORT_FW-1:0]         rsp_in_port,
   output logic [wmr_pkg::VALUE_W-1:0]         rsp_message_value,
   output logic [wmr_pkg::EVENT_W-1:0]         rsp_event_count,
   output logic [wmr_pkg::FILL_W-1:0]          rsp_inbox_fill
);

   localparam int NODE_W  = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
   localparam int PORT_W  = (PORTS_PER_NODE > 1) ? $clog2(PORTS_PER_NODE) : 1;
   localparam int SLOT_W  = (INBOX_DEPTH > 1) ? $clog2(INBOX_DEPTH) : 1;
   localparam int LVL_W   = $clog2(INBOX_DEPTH + 1);
   localparam int WIRE_W  = (NUM_WIRES > 1) ? $clog2(NUM_WIRES) : 1;
   localparam int IDX_W   = $clog2(NUM_WIRES + 1);
   localparam int NP      = NUM_NODES * PORTS_PER_NODE;
   localparam int PIDX_W  = (NP > 1) ? $clog2(NP) : 1;
   localparam int MDEPTH  = NUM_NODES * INBOX_DEPTH;
   localparam int MADDR_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
   localparam int NEED_W  = IDX_W;
   localparam int SUM_W   = NEED_W + LVL_W;

   // latched request word
   logic [wmr_pkg::OP_W-1:0]    op_ff;
   logic [wmr_pkg::NODE_FW-1:0] node_ff, tnode_ff;
   logic [wmr_pkg::PORT_FW-1:0] port_ff, tport_ff;
   logic [wmr_pkg::VALUE_W-1:0] value_ff;
   logic [wmr_pkg::WIDX_FW-1:0] widx_ff;
   logic                        flag_ff;
   logic [wmr_pkg::TTL_W-1:0]   ttl_ff;
   logic [wmr_pkg::TYPE_W-1:0]  stype_ff;

   logic [wmr_pkg::CLOCK_W-1:0] clock_ms_ff;

   // wire table
   logic                        w_valid_ff [NUM_WIRES];
   logic [wmr_pkg::NODE_FW-1:0] w_sn_ff    [NUM_WIRES];
   logic [wmr_pkg::PORT_FW-1:0] w_sp_ff    [NUM_WIRES];
   logic [wmr_pkg::NODE_FW-1:0] w_dn_ff    [NUM_WIRES];
   logic [wmr_pkg::PORT_FW-1:0] w_dp_ff    [NUM_WIRES];

   // port tables
   logic                        ip_latest_ff [NP];
   logic [wmr_pkg::TTL_W-1:0]   ip_ttl_ff    [NP];
   logic [wmr_pkg::TYPE_W-1:0]  op_type_ff   [NP];

   // inbox ring per node
   wmr_pkg::wmr_entry_type      mem [MDEPTH];
   wmr_pkg::wmr_entry_type      rd_ff;
   logic [LVL_W-1:0]            level_ff  [NUM_NODES];
   logic [SLOT_W-1:0]           head_ff   [NUM_NODES];
   logic [NEED_W-1:0]           needed_ff [NUM_NODES];

   // scan state
   logic [IDX_W-1:0]            idx_ff;
   logic [NODE_W-1:0]           cur_t_ff;
   logic [wmr_pkg::PORT_FW-1:0] cur_q_ff;
   logic                        cur_latest_ff;
   logic [wmr_pkg::TTL_W-1:0]   cur_ttl_ff;
   logic [LVL_W-1:0]            fj_ff, fpos_ff;
   logic                        hit_ff;

   logic [wmr_pkg::EVENT_W-1:0] events_ff;
   logic [wmr_pkg::PORT_FW-1:0] rport_ff;
   logic [wmr_pkg::VALUE_W-1:0] rval_ff;

   logic                        rsp_valid_ff;
   logic [wmr_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [wmr_pkg::PORT_FW-1:0] rsp_in_port_ff;
   logic [wmr_pkg::VALUE_W-1:0] rsp_value_ff;
   logic [wmr_pkg::EVENT_W-1:0] rsp_event_ff;
   logic [wmr_pkg::FILL_W-1:0]  rsp_fill_ff;

   function automatic logic [SLOT_W-1:0] ring_slot(input logic [SLOT_W-1:0] head,
                                                   input logic [LVL_W-1:0] j);
      logic [SLOT_W:0] s;
      s = {1'b0, head} + (SLOT_W + 1)'(j);
      if (s >= (SLOT_W + 1)'(INBOX_DEPTH)) begin
         s = s - (SLOT_W + 1)'(INBOX_DEPTH);
      end
      return SLOT_W'(s);
   endfunction

   function automatic logic [MADDR_W-1:0] mem_addr(input logic [NODE_W-1:0] n,
                                                   input logic [SLOT_W-1:0] s);
      return MADDR_W'(32'(n) * INBOX_DEPTH + 32'(s));
   endfunction

   logic                        node_ok, port_ok, widx_ok;
   logic [NODE_W-1:0]           nidx;
   logic [PIDX_W-1:0]           pflat, wflat;
   logic [WIRE_W-1:0]           wi, wwi;
   logic [wmr_pkg::TYPE_W-1:0]  out_type;
   logic [LVL_W-1:0]            level_t, level_n, at;
   logic [SLOT_W-1:0]           head_t, head_n;
   logic                        replace;
   logic [NEED_W-1:0]           need_nx;
   logic [MADDR_W-1:0]          rd_addr, wr_addr;
   wmr_pkg::wmr_entry_type      wr_entry;

   assign node_ok  = 32'(node_ff) < NUM_NODES;
   assign port_ok  = 32'(port_ff) < PORTS_PER_NODE;
   assign widx_ok  = 32'(widx_ff) < NUM_WIRES;
   assign nidx     = NODE_W'(node_ff);
   assign pflat    = PIDX_W'(32'(nidx) * PORTS_PER_NODE + 32'(PORT_W'(port_ff)));
   assign wi       = WIRE_W'(idx_ff);
   assign wwi      = WIRE_W'(widx_ff);
   assign wflat    = PIDX_W'(32'(NODE_W'(w_dn_ff[wi])) * PORTS_PER_NODE
                             + 32'(PORT_W'(w_dp_ff[wi])));
   assign out_type = op_type_ff[pflat];
   assign level_t  = level_ff[cur_t_ff];
   assign head_t   = head_ff[cur_t_ff];
   assign level_n  = level_ff[nidx];
   assign head_n   = head_ff[nidx];
   assign replace  = cur_latest_ff && hit_ff;
   assign need_nx  = needed_ff[cur_t_ff] + (replace ? NEED_W'(0) : NEED_W'(1));
   assign at       = replace ? fpos_ff : level_t;
   assign rd_addr  = cmd.find_read ? mem_addr(cur_t_ff, ring_slot(head_t, fj_ff))
                                   : mem_addr(nidx, head_n);
   assign wr_addr  = mem_addr(cur_t_ff, ring_slot(head_t, at));

   always_comb begin
      wr_entry.expiry = (cur_ttl_ff != '0)
                        ? clock_ms_ff + wmr_pkg::CLOCK_W'(cur_ttl_ff) : '0;
      wr_entry.port   = cur_q_ff;
      wr_entry.value  = value_ff;
   end

   always_comb begin
      stat             = '0;
      stat.op          = op_ff;
      stat.node_ok     = node_ok;
      stat.emit_undecl = !node_ok || !port_ok || out_type == wmr_pkg::SIG_NONE
                         || out_type > wmr_pkg::SIG_BOOL_B;
      stat.value_bad   = !wmr_pkg::value_fits(out_type, value_ff);
      stat.idx_end     = idx_ff == IDX_W'(NUM_WIRES);
      stat.wire_use    = w_valid_ff[wi] && w_sn_ff[wi] == node_ff && w_sp_ff[wi] == port_ff
                         && 32'(w_dn_ff[wi]) < NUM_NODES
                         && 32'(w_dp_ff[wi]) < PORTS_PER_NODE;
      stat.find_done   = !cur_latest_ff || hit_ff || (fj_ff >= level_t);
      stat.pf_full     = (SUM_W'(level_t) + SUM_W'(need_nx)) > SUM_W'(INBOX_DEPTH);
      stat.rx_empty    = level_n == '0;
      stat.rx_expired  = rd_ff.expiry != '0 && clock_ms_ff >= rd_ff.expiry;
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // request capture and scan registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         node_ff  <= req_node;
         port_ff  <= req_port;
         value_ff <= req_value;
         widx_ff  <= req_wire_index;
         tnode_ff <= req_target_node;
         tport_ff <= req_target_port;
         flag_ff  <= req_flag;
         ttl_ff   <= req_expiry_ms;
         stype_ff <= req_signal_type;
      end
      if (cmd.wire_load) begin
         cur_t_ff      <= NODE_W'(w_dn_ff[wi]);
         cur_q_ff      <= w_dp_ff[wi];
         cur_latest_ff <= ip_latest_ff[wflat];
         cur_ttl_ff    <= ip_ttl_ff[wflat];
         fj_ff         <= '0;
         hit_ff        <= 1'b0;
      end else if (cmd.find_cmp) begin
         if (rd_ff.port == cur_q_ff) begin
            hit_ff  <= 1'b1;
            fpos_ff <= fj_ff;
         end else begin
            fj_ff <= fj_ff + LVL_W'(1);
         end
      end
      if (cmd.capture) begin
         events_ff <= '0;
         rport_ff  <= '0;
         rval_ff   <= '0;
      end else if (cmd.deliver || cmd.rx_drop) begin
         events_ff <= events_ff + wmr_pkg::EVENT_W'(1);
      end else if (cmd.rx_pop) begin
         rport_ff <= rd_ff.port;
         rval_ff  <= rd_ff.value;
      end
      if (cmd.emit_init || cmd.dl_init) begin
         idx_ff <= '0;
      end else if (cmd.idx_next || cmd.pf_count || cmd.deliver) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // wire table payload
   always_ff @(posedge clock) begin
      if (cmd.tbl_write && op_ff == wmr_pkg::OP_WIRE && widx_ok) begin
         w_sn_ff[wwi] <= node_ff;
         w_sp_ff[wwi] <= port_ff;
         w_dn_ff[wwi] <= tnode_ff;
         w_dp_ff[wwi] <= tport_ff;
      end
   end

   // tables, clock and inbox control
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ms_ff <= '0;
         for (int i = 0; i < NUM_WIRES; i++) begin
            w_valid_ff[i] <= 1'b0;
         end
         for (int i = 0; i < NP; i++) begin
            ip_latest_ff[i] <= 1'b0;
            ip_ttl_ff[i]    <= '0;
            op_type_ff[i]   <= wmr_pkg::SIG_NONE;
         end
         for (int i = 0; i < NUM_NODES; i++) begin
            level_ff[i]  <= '0;
            head_ff[i]   <= '0;
            needed_ff[i] <= '0;
         end
      end else begin
         if (cmd.tick) begin
            clock_ms_ff <= clock_ms_ff + wmr_pkg::CLOCK_W'(1);
         end
         if (cmd.tbl_write) begin
            case (op_ff)
               wmr_pkg::OP_WIRE: begin
                  if (widx_ok) begin
                     w_valid_ff[wwi] <= flag_ff;
                  end
               end
               wmr_pkg::OP_IN_PORT: begin
                  if (node_ok && port_ok) begin
                     ip_latest_ff[pflat] <= flag_ff;
                     ip_ttl_ff[pflat]    <= (ttl_ff > wmr_pkg::TTL_MAX)
                                            ? wmr_pkg::TTL_MAX : ttl_ff;
                  end
               end
               wmr_pkg::OP_OUT_PORT: begin
                  if (node_ok && port_ok) begin
                     op_type_ff[pflat] <= stype_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd.emit_init) begin
            for (int i = 0; i < NUM_NODES; i++) begin
               needed_ff[i] <= '0;
            end
         end
         if (cmd.pf_count) begin
            needed_ff[cur_t_ff] <= need_nx;
         end
         // append grows the ring; an overwrite leaves the level alone
         if (cmd.deliver && !replace) begin
            level_ff[cur_t_ff] <= level_t + LVL_W'(1);
         end
         if (cmd.rx_drop || cmd.rx_pop) begin
            level_ff[nidx] <= level_n - LVL_W'(1);
            head_ff[nidx]  <= (32'(head_n) == INBOX_DEPTH - 1) ? '0 : head_n + SLOT_W'(1);
         end
      end
   end

   // inbox memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         mem[wr_addr] <= wr_entry;
      end
      if (cmd.find_read || cmd.rx_read) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff  <= cmd.status;
         rsp_in_port_ff <= rport_ff;
         rsp_value_ff   <= rval_ff;
         rsp_event_ff   <= events_ff;
         rsp_fill_ff    <= node_ok ? wmr_pkg::FILL_W'(level_n) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_in_port       = rsp_in_port_ff;
   assign rsp_message_value = rsp_value_ff;
   assign rsp_event_count   = rsp_event_ff;
   assign rsp_inbox_fill    = rsp_fill_ff;

endmodule

// ===== rtl/wired_mailbox_router.sv =====
// Top level of the wired mailbox router: sequencer plus datapath.
// Depends on wmr_pkg, wmr_ctrl and wmr_dpath.
//
//   channel   direction   handshake             word
//   req_      in          req_valid/req_ready   op, node, port, value, wire and port fields
//   rsp_      out         rsp_valid/rsp_ready   status, in_port, message_value, counts, fill
//
// Tick, table writes and rejected emits pass from accept through dispatch to
// the result register. A receive reads entries from the inbox head, dropping
// each expired one, until it pops a live entry or finds the inbox empty. An
// emit scans every wire twice, preflight then delivery, and on a latest port
// searches the target inbox entry by entry, since every search goes through
// the single read port of the inbox memory; a full inbox ends the first scan
// early. One word is worked at a time; the next is accepted once the result is
// registered, and a result not yet taken holds the following one in its last cycle.
// Synchronous reset clears the tables, inbox levels and clock; no clearing pass.
`timescale 1ns / 1ps

module wired_mailbox_router #(
   parameter int NUM_NODES      = 8,
   parameter int PORTS_PER_NODE = 4,
   parameter int INBOX_DEPTH    = 8,
   parameter int NUM_WIRES      = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [wmr_pkg::OP_W-1:0]      req_op,
   input  logic [wmr_pkg::NODE_FW-1:0]   req_node,
   input  logic [wmr_pkg::PORT_FW-1:0]   req_port,
   input  logic [wmr_pkg::VALUE_W-1:0]   req_value,
   input  logic [wmr_pkg::WIDX_FW-1:0]   req_wire_index,
   input  logic [wmr_pkg::NODE_FW-1:0]   req_target_node,
   input  logic [wmr_pkg::PORT_FW-1:0]   req_target_port,
   input  logic                          req_flag,
   input  logic [wmr_pkg::TTL_W-1:0]     req_expiry_ms,
   input  logic [wmr_pkg::TYPE_W-1:0]    req_signal_type,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [wmr_pkg::STATUS_W-1:0]  rsp_status,
   output logic [wmr_pkg::PORT_FW-1:0]   rsp_in_port,
   output logic [wmr_pkg::VALUE_W-1:0]   rsp_message_value,
   output logic [wmr_pkg::EVENT_W-1:0]   rsp_event_count,
   output logic [wmr_pkg::FILL_W-1:0]    rsp_inbox_fill
);

   wmr_pkg::wmr_cmd_type  cmd;
   wmr_pkg::wmr_stat_type stat;

   wmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wmr_dpath #(
      .NUM_NODES      (NUM_NODES),
      .PORTS_PER_NODE (PORTS_PER_NODE),
      .INBOX_DEPTH    (INBOX_DEPTH),
      .NUM_WIRES      (NUM_WIRES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_node          (req_node),
      .req_port          (req_port),
      .req_value         (req_value),
      .req_wire_index    (req_wire_index),
      .req_target_node   (req_target_node),
      .req_target_port   (req_target_port),
      .req_flag          (req_flag),
      .req_expiry_ms     (req_expiry_ms),
      .req_signal_type   (req_signal_type),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_in_port       (rsp_in_port),
      .rsp_message_value (rsp_message_value),
      .rsp_event_count   (rsp_event_count),
      .rsp_inbox_fill    (rsp_inbox_fill)
   );

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a word while the previous one was in flight");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a word being worked");

   a_reject_no_events: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == wmr_pkg::ST_FULL || rsp_status == wmr_pkg::ST_RANGE
                    || rsp_status == wmr_pkg::ST_UNDECL) |-> rsp_event_count == '0)
      else $error("rejected emit reported deliveries");

   a_empty_no_message: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == wmr_pkg::ST_EMPTY |->
      rsp_message_value == '0 && rsp_in_port == '0)
      else $error("empty receive returned a message");
`endif

endmodule
